>>> rtl/oar_pkg.sv
// ----------------------------------------------------------------------------
// oar_pkg
// Types and codes shared by the overlap-add output ring: payload structs,
// opcodes, status codes, read formats and register indexes.
// ----------------------------------------------------------------------------
package oar_pkg;

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  localparam logic [1:0] FMT_S32 = 2'd0;
  localparam logic [1:0] FMT_S24 = 2'd1;
  localparam logic [1:0] FMT_S16 = 2'd2;

  localparam int FSW = 11;  // frame_size / hop_size / frame index width

  typedef enum logic [1:0] {
    REG_GAIN   = 2'd0,
    REG_FRAME  = 2'd1,
    REG_HOP    = 2'd2,
    REG_FORMAT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] frame_sample;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sample_out;
    logic [1:0]         status;
    logic               frame_done;
  } out_t;

endpackage

>>> rtl/overlap_add_output_ring.sv
// Pipeline: two register stages, stage 1 and the result register; an accepted
//   item reaches the output (out_valid) once the result register is free.
// Throughput: one item per cycle while the output is not stalled; each item
//   does one read-modify-write of the ring memory, with a write-to-read bypass
//   between back-to-back items. Reset: control and configuration return to
//   defaults, then a clearing pass zeroes every ring slot with in_ready low.
// ----------------------------------------------------------------------------
// overlap_add_output_ring
// Single-channel overlap-add store: gain-scaled accumulate into the ring at
// frame start plus index, and formatted read-and-clear of the oldest sample.
// ----------------------------------------------------------------------------
module overlap_add_output_ring #(
  parameter int RING_DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          in_valid,
  output logic          in_ready,
  input  oar_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output oar_pkg::out_t out_item
);

  localparam int AW   = $clog2(RING_DEPTH);
  localparam int CW   = $clog2(RING_DEPTH + 1);
  localparam int CMPW = (CW > oar_pkg::FSW) ? CW : oar_pkg::FSW;
  localparam int SW   = CMPW + 1;

  // configuration
  logic signed [31:0]         gain_q31;
  logic [oar_pkg::FSW-1:0]    frame_size;
  logic [oar_pkg::FSW-1:0]    hop_size;
  logic [1:0]                 output_format;

  // control state
  logic                       clearing;
  logic [AW-1:0]              clr_cnt;
  logic [AW-1:0]              frame_start;
  logic [AW-1:0]              wr_pos;
  logic [AW-1:0]              read_pos;
  logic [oar_pkg::FSW-1:0]    frame_index;
  logic [CW-1:0]              avail_count;

  // ring memory
  logic signed [31:0]         ring_store [RING_DEPTH];
  logic signed [31:0]         mem_rd;
  logic                       mem_we;
  logic [AW-1:0]              mem_wa;
  logic signed [31:0]         mem_wd;

  // stage 1
  logic                       s1_valid;
  logic                       s1_op;
  logic                       s1_wr;
  logic [AW-1:0]              s1_addr;
  logic signed [33:0]         s1_phi;
  logic [1:0]                 s1_status;
  logic                       s1_done;
  logic                       s1_fwd;
  logic signed [31:0]         s1_fwd_data;
  logic                       s1_adv;

  logic                       cfg_wr;
  logic                       accept;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q31      <= 32'sh7FFF_FFFF;
      frame_size    <= 11'd512;
      hop_size      <= 11'd128;
      output_format <= oar_pkg::FMT_S32;
    end else if (cfg_wr) begin
      case (oar_pkg::reg_idx_t'(paddr[3:2]))
        oar_pkg::REG_GAIN:   gain_q31      <= $signed(pwdata);
        oar_pkg::REG_FRAME:  frame_size    <= pwdata[oar_pkg::FSW-1:0];
        oar_pkg::REG_HOP:    hop_size      <= pwdata[oar_pkg::FSW-1:0];
        oar_pkg::REG_FORMAT: output_format <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (oar_pkg::reg_idx_t'(paddr[3:2]))
      oar_pkg::REG_GAIN:   prdata = gain_q31;
      oar_pkg::REG_FRAME:  prdata = {21'd0, frame_size};
      oar_pkg::REG_HOP:    prdata = {21'd0, hop_size};
      oar_pkg::REG_FORMAT: prdata = {30'd0, output_format};
      default:             prdata = 32'd0;
    endcase
  end

  // hop reduced modulo the ring depth: at most 31 wraps since depth >= 64
  logic [oar_pkg::FSW-1:0] hop_mod;
  always_comb begin
    hop_mod = hop_size;
    for (int k = 4; k >= 0; k--) begin
      if (32'(hop_mod) >= (RING_DEPTH << k)) begin
        hop_mod = hop_mod - oar_pkg::FSW'(RING_DEPTH << k);
      end
    end
  end

  // accept-time decisions, from control state and configuration
  logic [CW-1:0]    free_space;
  logic             acc_reject;
  logic             acc_done;
  logic             rd_empty;
  logic [AW:0]      fs_sum;
  logic [AW-1:0]    fs_next;
  logic [AW:0]      wr_inc;
  logic [AW:0]      rd_inc;
  logic [SW-1:0]    avail_sum;
  logic [AW-1:0]    rd_addr;
  logic             s0_wr;
  logic             wr_now;

  assign accept     = in_valid && in_ready;
  assign free_space = CW'(RING_DEPTH) - avail_count;
  assign acc_reject = (frame_index == '0) && (CMPW'(free_space) < CMPW'(frame_size));
  assign acc_done   = ({1'b0, frame_index} + 12'd1) >= {1'b0, frame_size};
  assign rd_empty   = (avail_count == '0);
  assign fs_sum     = (AW+1)'(frame_start) + (AW+1)'(hop_mod);
  assign fs_next    = (fs_sum >= (AW+1)'(RING_DEPTH)) ?
                      AW'(fs_sum - (AW+1)'(RING_DEPTH)) : AW'(fs_sum);
  assign wr_inc     = (AW+1)'(wr_pos) + (AW+1)'(1);
  assign rd_inc     = (AW+1)'(read_pos) + (AW+1)'(1);
  assign avail_sum  = SW'(avail_count) + SW'(hop_size);
  assign rd_addr    = (in_item.opcode == oar_pkg::OP_READ) ? read_pos : wr_pos;
  assign s0_wr      = (in_item.opcode == oar_pkg::OP_READ) ? !rd_empty : !acc_reject;
  assign wr_now     = s1_valid && s1_adv && s1_wr;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clearing && (!s1_valid || s1_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing    <= 1'b1;
      clr_cnt     <= '0;
      frame_start <= '0;
      wr_pos      <= '0;
      read_pos    <= '0;
      frame_index <= '0;
      avail_count <= '0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (clr_cnt == AW'(RING_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        if (in_item.opcode == oar_pkg::OP_ACC) begin
          if (!acc_reject) begin
            if (acc_done) begin
              frame_index <= '0;
              frame_start <= fs_next;
              wr_pos      <= fs_next;
              avail_count <= (avail_sum > SW'(RING_DEPTH)) ? CW'(RING_DEPTH) : CW'(avail_sum);
            end else begin
              frame_index <= frame_index + oar_pkg::FSW'(1);
              wr_pos      <= (wr_inc == (AW+1)'(RING_DEPTH)) ? '0 : AW'(wr_inc);
            end
          end
        end else if (!rd_empty) begin
          read_pos    <= (rd_inc == (AW+1)'(RING_DEPTH)) ? '0 : AW'(rd_inc);
          avail_count <= avail_count - CW'(1);
        end
      end
    end
  end

  // stage 1 capture: gain product, address, decision, bypass of the write
  // retiring at this same edge
  logic signed [63:0] prod;
  assign prod = gain_q31 * $signed(in_item.frame_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= in_item.opcode;
      s1_wr       <= s0_wr;
      s1_addr     <= rd_addr;
      s1_phi      <= prod[63:30];
      s1_done     <= (in_item.opcode == oar_pkg::OP_ACC) && !acc_reject && acc_done;
      s1_fwd      <= wr_now && (s1_addr == rd_addr);
      s1_fwd_data <= mem_wd;
      if (in_item.opcode == oar_pkg::OP_READ) begin
        s1_status <= rd_empty ? oar_pkg::ST_EMPTY : oar_pkg::ST_OK;
      end else begin
        s1_status <= acc_reject ? oar_pkg::ST_REJECT : oar_pkg::ST_OK;
      end
    end
  end

  // stage 1 compute
  logic signed [31:0] cur;
  logic signed [34:0] rnd_t;
  logic signed [32:0] rnd;
  logic signed [33:0] sum;
  logic signed [31:0] acc_val;
  logic signed [17:0] q_t;
  logic signed [16:0] q;
  logic signed [15:0] s16;
  logic signed [31:0] fmt_val;
  logic signed [31:0] s1_wd;

  assign cur   = s1_fwd ? s1_fwd_data : mem_rd;
  assign rnd_t = {s1_phi[33], s1_phi} + 35'sd1;
  assign rnd   = rnd_t[33:1];
  assign sum   = {rnd[32], rnd} + {{2{cur[31]}}, cur};

  always_comb begin
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      acc_val = sum[31:0];
    end else if (sum[33]) begin
      acc_val = 32'sh8000_0000;
    end else begin
      acc_val = 32'sh7FFF_FFFF;
    end
  end

  assign q_t = {cur[31], cur[31:15]} + 18'sd1;
  assign q   = q_t[17:1];

  always_comb begin
    if (q[16:15] == 2'b00 || q[16:15] == 2'b11) begin
      s16 = q[15:0];
    end else if (q[16]) begin
      s16 = 16'sh8000;
    end else begin
      s16 = 16'sh7FFF;
    end
    case (output_format)
      oar_pkg::FMT_S24: fmt_val = {{8{cur[31]}}, cur[31:8]};
      oar_pkg::FMT_S16: fmt_val = {{16{s16[15]}}, s16};
      default:          fmt_val = cur;
    endcase
  end

  // a read clears its slot
  assign s1_wd = (s1_op == oar_pkg::OP_READ) ? 32'sd0 : acc_val;

  assign mem_we = clearing || wr_now;
  assign mem_wa = clearing ? clr_cnt : s1_addr;
  assign mem_wd = clearing ? 32'sd0 : s1_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_store[mem_wa] <= mem_wd;
    end
    if (accept) begin
      mem_rd <= ring_store[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item.sample_out <= (s1_op == oar_pkg::OP_READ && s1_status == oar_pkg::ST_OK) ?
                             fmt_val : 32'sd0;
      out_item.status     <= s1_status;
      out_item.frame_done <= s1_done;
    end
  end

  // checks
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("item accepted during clearing pass");

  a_avail_bound: assert property (@(posedge clk) disable iff (rst)
    avail_count <= CW'(RING_DEPTH))
    else $error("available count beyond ring depth");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_addr) && $stable(s1_status))
    else $error("stalled stage 1 item changed");

  a_no_write_on_fail: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_status != oar_pkg::ST_OK |-> !s1_wr)
    else $error("ring written by rejected or empty item");

  a_done_acc: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_done |-> s1_op == oar_pkg::OP_ACC && s1_status == oar_pkg::ST_OK)
    else $error("frame done flagged on non-accumulate item");

endmodule
